// ===== hw/rtl/dpw_pkg.sv =====
// dpw_pkg: shared types and constants of the dose pump watchdog
// no dependencies; imported by every module of the block
`default_nettype none

package dpw_pkg;

  localparam int PUMPS_DEF   = 4;
  localparam int TICK_MS     = 10;
  localparam int FAULT_BITS  = 13;
  localparam int REG_COUNT   = 4;
  localparam int LIMIT_W     = 24;
  localparam int ELAPSED_W   = 32;
  localparam int CMD_W       = 3;
  localparam int CHAN_W      = 2;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_ON    = 3'd1,
    CMD_OFF   = 3'd2,
    CMD_PULSE = 3'd3,
    CMD_RAISE = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_e;

  // one request as it leaves the input register
  typedef struct packed {
    logic                  valid;
    cmd_e                  command;
    logic [CHAN_W-1:0]     channel;
    logic [LIMIT_W-1:0]    pulse_len;
    logic [FAULT_BITS-1:0] fault_bits;
  } step_t;

  typedef logic [LIMIT_W-1:0] limit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dpw_apb_regs.sv =====
// dpw_apb_regs: apb register file for the per-pump maximum on times
// depends on dpw_pkg
`default_nettype none

module dpw_apb_regs
  import dpw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output limit_t                     limits [REG_COUNT]
);

  limit_t                 limit_reg [REG_COUNT];
  logic   [REG_IDX_W-1:0] reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        limit_reg[i] <= '0;
      end
    end else if (wr_en) begin
      limit_reg[reg_idx] <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_reg[reg_idx]};

  always_comb begin
    for (int i = 0; i < REG_COUNT; i++) begin
      limits[i] = limit_reg[i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dpw_pump_timer.sv =====
// dpw_pump_timer: run flag and elapsed-ms accumulator of one pump
// depends on dpw_pkg
`default_nettype none

module dpw_pump_timer
  import dpw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire step_t  step,
  input  wire logic   sel,
  input  wire limit_t limit,
  output logic        raise
);

  logic                 running;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic                 enabled;

  // elapsed ms wraps at 32 bits, same as ticks since start times tick length
  assign elapsed_next = elapsed + ELAPSED_W'(TICK_MS);
  assign enabled      = (limit != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (step.valid) begin
      case (step.command)
        CMD_ON:  if (sel && enabled && !running) running <= 1'b1;
        CMD_OFF: if (sel && enabled) running <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      case (step.command)
        CMD_TICK: elapsed <= elapsed_next;
        CMD_ON:   if (sel && enabled && !running) elapsed <= '0;
        default:  ;
      endcase
    end
  end

  always_comb begin
    raise = 1'b0;
    if (step.valid && enabled) begin
      case (step.command)
        CMD_TICK:  raise = running && (elapsed_next > {{(ELAPSED_W-LIMIT_W){1'b0}}, limit});
        CMD_PULSE: raise = sel && (step.pulse_len > limit);
        default:   raise = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dpw_fault_latch.sv =====
// dpw_fault_latch: latched fault mask and safe-mode flag
// depends on dpw_pkg
`default_nettype none

module dpw_fault_latch
  import dpw_pkg::*;
#(
  parameter int PUMPS = PUMPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire step_t                 step,
  input  wire logic [PUMPS-1:0]      pump_raise,
  output logic      [FAULT_BITS-1:0] mask_next,
  output logic      [FAULT_BITS-1:0] fresh,
  output logic                       safe_next,
  output logic                       cleared
);

  logic [FAULT_BITS-1:0] latched;
  logic                  safe_flag;
  logic [FAULT_BITS-1:0] raise_bits;
  logic [FAULT_BITS-1:0] clr_bits;

  always_comb begin
    raise_bits = '0;
    raise_bits[PUMPS-1:0] = pump_raise;
    if (step.command == CMD_RAISE) begin
      raise_bits = step.fault_bits;
    end
    clr_bits = (step.fault_bits == '0) ? latched : step.fault_bits;
  end

  always_comb begin
    mask_next = latched;
    fresh     = '0;
    safe_next = safe_flag;
    cleared   = 1'b0;
    if (step.valid) begin
      case (step.command)
        CMD_CLEAR: begin
          mask_next = latched & ~clr_bits;
          if (mask_next == '0) begin
            safe_next = 1'b0;
            cleared   = 1'b1;
          end
        end
        default: begin
          fresh     = raise_bits & ~latched;
          mask_next = latched | raise_bits;
          if (fresh != '0) safe_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched   <= '0;
      safe_flag <= 1'b0;
    end else begin
      latched   <= mask_next;
      safe_flag <= safe_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dose_pump_watchdog_core.sv =====
// dose_pump_watchdog_core: on-time watchdog for dosing pumps, top level
// a request passes the input register, then the result register
// throughput: 1 request per cycle while out_ready holds; all pumps are checked in parallel in one pass
// reset: synchronous active-high rst clears limits, run flags, faults, safe mode
// depends on dpw_pkg, dpw_apb_regs, dpw_pump_timer, dpw_fault_latch
`default_nettype none

module dose_pump_watchdog_core
  import dpw_pkg::*;
#(
  parameter int PUMPS = PUMPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // apb configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CMD_W-1:0]      command,
  input  wire logic [CHAN_W-1:0]     channel,
  input  wire logic [LIMIT_W-1:0]    pulse_len,
  input  wire logic [FAULT_BITS-1:0] fault_bits,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [FAULT_BITS-1:0] fault_mask,
  output logic      [FAULT_BITS-1:0] raised_faults,
  output logic                       safe_state,
  output logic                       safe_released
);

  // input register stage
  step_t                 s1;
  logic                  advance;
  step_t                 step;

  // per-pump limits and raise requests
  limit_t                limits [REG_COUNT];
  logic [PUMPS-1:0]      pump_raise;

  // next result values from the fault latch
  logic [FAULT_BITS-1:0] mask_next;
  logic [FAULT_BITS-1:0] fresh;
  logic                  safe_next;
  logic                  cleared;

  // the result register frees itself when taken, so a new request moves on every cycle while out_ready holds
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1.valid || advance;

  // valid is reset, the request payload needs none
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (in_ready) begin
      s1.valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1.command    <= cmd_e'(command);
      s1.channel    <= channel;
      s1.pulse_len  <= pulse_len;
      s1.fault_bits <= fault_bits;
    end
  end

  // the request acts on state only in the cycle it moves into the result register
  always_comb begin
    step       = s1;
    step.valid = s1.valid && advance;
  end

  dpw_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  // one timer per pump; pumps without a register behave as disabled
  for (genvar p = 0; p < PUMPS; p++) begin : g_pump
    limit_t pump_limit;
    logic   pump_sel;

    if (p < REG_COUNT) begin : g_lim
      assign pump_limit = limits[p];
    end else begin : g_nolim
      assign pump_limit = '0;
    end

    assign pump_sel = (32'(step.channel) == p);

    dpw_pump_timer u_timer (
      .clk   (clk),
      .rst   (rst),
      .step  (step),
      .sel   (pump_sel),
      .limit (pump_limit),
      .raise (pump_raise[p])
    );
  end

  dpw_fault_latch #(
    .PUMPS (PUMPS)
  ) u_faults (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .pump_raise (pump_raise),
    .mask_next  (mask_next),
    .fresh      (fresh),
    .safe_next  (safe_next),
    .cleared    (cleared)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid) begin
      fault_mask    <= mask_next;
      raised_faults <= fresh;
      safe_state    <= safe_next;
      safe_released <= cleared;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for dose_pump_watchdog_core, with a watchdog predictor,
// a directed table and random phases of requests; random stalls on both channels
// depends on dpw_pkg and the dose_pump_watchdog_core rtl
`timescale 1ns / 1ps

module tb_top
  import dpw_pkg::*;
();

  // command codes the block does not define, still legal on the 3-bit port
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  // register map, one 24-bit limit per pump, byte address 4*index
  typedef enum int {
    REG_DOSE_A    = 0,
    REG_DOSE_B    = 1,
    REG_DOSE_UP   = 2,
    REG_DOSE_DOWN = 3
  } dose_reg_e;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic [FAULT_BITS-1:0] fault_mask;
    logic [FAULT_BITS-1:0] raised_faults;
    logic                  safe_state;
    logic                  safe_released;
  } result_t;

  // one row of the directed table: either a register write or a request
  typedef struct {
    bit                    is_cfg;
    logic [CMD_W-1:0]      cmd;
    logic [CHAN_W-1:0]     ch;
    logic [LIMIT_W-1:0]    pulse;
    logic [FAULT_BITS-1:0] bits;
    bit                    typed;
    result_t               want;
  } dir_row_t;

  localparam result_t QUIET = '{13'h0, 13'h0, 1'b0, 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command    = '0;
  logic [CHAN_W-1:0]     channel    = '0;
  logic [LIMIT_W-1:0]    pulse_len  = '0;
  logic [FAULT_BITS-1:0] fault_bits = '0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FAULT_BITS-1:0] fault_mask;
  logic [FAULT_BITS-1:0] raised_faults;
  logic                  safe_state;
  logic                  safe_released;

  // predictor copy of the block state and its limit registers
  logic [LIMIT_W-1:0]    dose_limit [REG_COUNT];
  logic [31:0]           tick_now;
  bit                    pump_on    [PUMPS_DEF];
  logic [31:0]           pump_since [PUMPS_DEF];
  logic [FAULT_BITS-1:0] latched;
  bit                    safe;

  result_t  expected_results [$];
  dir_row_t dir_rows [$];
  int       mismatches  = 0;
  int       idle_cycles = 0;
  int       stall_left  = 0;
  // when set, neither side inserts gaps or stalls
  bit       calm = 1'b0;
  result_t  seen_result;
  result_t  due_result;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  dose_pump_watchdog_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .channel       (channel),
    .pulse_len     (pulse_len),
    .fault_bits    (fault_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fault_mask    (fault_mask),
    .raised_faults (raised_faults),
    .safe_state    (safe_state),
    .safe_released (safe_released)
  );

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // gap length: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(25, 60);
  endfunction

  // latch fault bits, hand back the ones that were not set before
  function automatic logic [FAULT_BITS-1:0] latch_faults(logic [FAULT_BITS-1:0] b);
    logic [FAULT_BITS-1:0] fresh;
    fresh   = b & ~latched;
    latched = latched | b;
    if (fresh != '0) begin
      safe = 1'b1;
    end
    return fresh;
  endfunction

  function automatic void reset_watchdog_model();
    for (int i = 0; i < PUMPS_DEF; i++) begin
      pump_on[i]    = 1'b0;
      pump_since[i] = '0;
    end
    for (int i = 0; i < REG_COUNT; i++) begin
      dose_limit[i] = '0;
    end
    tick_now = '0;
    latched  = '0;
    safe     = 1'b0;
  endfunction

  // advance the watchdog state by one request and give the result it causes
  function automatic result_t predict_watchdog(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                               logic [LIMIT_W-1:0] pulse,
                                               logic [FAULT_BITS-1:0] bits);
    logic [FAULT_BITS-1:0] fresh;
    logic [FAULT_BITS-1:0] sel;
    logic [31:0]           elapsed;
    logic [LIMIT_W-1:0]    lim;
    bit                    cleared;
    result_t               r;
    fresh   = '0;
    cleared = 1'b0;
    lim     = dose_limit[ch];
    case (cmd)
      CMD_TICK: begin
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < PUMPS_DEF; i++) begin
          if (pump_on[i] && dose_limit[i] != '0) begin
            // elapsed ms wraps at 32 bits, like the block's counter
            elapsed = (tick_now - pump_since[i]) * 32'(TICK_MS);
            if (elapsed > {8'h00, dose_limit[i]}) begin
              fresh = fresh | latch_faults(FAULT_BITS'(1) << i);
            end
          end
        end
      end
      CMD_ON: begin
        // a second on keeps the original start tick
        if (lim != '0 && !pump_on[ch]) begin
          pump_on[ch]    = 1'b1;
          pump_since[ch] = tick_now;
        end
      end
      CMD_OFF: begin
        if (lim != '0) begin
          pump_on[ch]    = 1'b0;
          pump_since[ch] = '0;
        end
      end
      CMD_PULSE: begin
        if (lim != '0 && pulse > lim) begin
          fresh = latch_faults(FAULT_BITS'(1) << ch);
        end
      end
      CMD_RAISE: begin
        fresh = latch_faults(bits);
      end
      CMD_CLEAR: begin
        // clear with an empty mask wipes everything
        sel     = (bits == '0) ? latched : bits;
        latched = latched & ~sel;
        if (latched == '0) begin
          safe    = 1'b0;
          cleared = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.fault_mask    = latched;
    r.raised_faults = fresh;
    r.safe_state    = safe;
    r.safe_released = cleared;
    return r;
  endfunction

  function automatic void table_row(bit is_cfg, logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                                    logic [LIMIT_W-1:0] pulse, logic [FAULT_BITS-1:0] bits,
                                    bit typed, result_t want);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.cmd    = cmd;
    row.ch     = ch;
    row.pulse  = pulse;
    row.bits   = bits;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endfunction

  // drop the request valid and let every outstanding result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // apb write of one limit register followed by a read back
  task automatic program_limit(int idx, logic [LIMIT_W-1:0] value);
    logic [APB_DATA_W-1:0] wdata;
    wait_idle();
    // upper bits are junk, the register keeps only 24 of them
    wdata   = {8'($urandom()), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dose_limit[idx] = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {8'h00, value}) begin
      flag_mismatch($sformatf("limit %0d read back: expected %h, got %h",
                              idx, {8'h00, value}, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // present one request, wait for its accept, then queue what it should return
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [CHAN_W-1:0] ch,
                              logic [LIMIT_W-1:0] pulse, logic [FAULT_BITS-1:0] bits,
                              bit typed, result_t want);
    int      gap;
    result_t model;
    gap = (!calm && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    channel    <= ch;
    pulse_len  <= pulse;
    fault_bits <= bits;
    do @(posedge clk); while (!in_ready);
    model = predict_watchdog(cmd, ch, pulse, bits);
    expected_results.push_back(typed ? want : model);
  endtask

  // pick a limit: extremes, values close to whole ticks, and arbitrary ones
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return 24'hFF_FFFF;
      2: return 24'd1;
      7: return LIMIT_W'($urandom_range(1, 400));
      8: return LIMIT_W'($urandom());
      default: return LIMIT_W'(TICK_MS * $urandom_range(1, 12) + $urandom_range(0, 2) - 1);
    endcase
  endfunction

  // result side: random stalls, some long, none while calm
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result = '{fault_mask, raised_faults, safe_state, safe_released};
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: mask %h new %h safe %b clr %b",
                                fault_mask, raised_faults, safe_state, safe_released));
      end else begin
        due_result = expected_results.pop_front();
        if (seen_result.fault_mask !== due_result.fault_mask ||
            seen_result.raised_faults !== due_result.raised_faults ||
            seen_result.safe_state !== due_result.safe_state ||
            seen_result.safe_released !== due_result.safe_released) begin
          flag_mismatch($sformatf(
              "expected mask %h new %h safe %b clr %b, got mask %h new %h safe %b clr %b",
              due_result.fault_mask, due_result.raised_faults, due_result.safe_state,
              due_result.safe_released, seen_result.fault_mask, seen_result.raised_faults,
              seen_result.safe_state, seen_result.safe_released));
        end
      end
    end
  end

  // hang detector: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("dose_pump_watchdog_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CMD_W-1:0]      cmd;
    logic [CHAN_W-1:0]     ch;
    logic [LIMIT_W-1:0]    pulse;
    logic [FAULT_BITS-1:0] bits;
    int                    r;

    reset_watchdog_model();

    // limits are all zero here, so pump commands must do nothing
    table_row(0, CMD_ON,     2'd0, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_PULSE,  2'd1, 24'hFF_FFFF, 13'h0,    1, QUIET);
    table_row(0, CMD_RAISE,  2'd0, 24'd0,       13'h0,    1, QUIET);
    // clear on an empty mask still reports the safe mode drop
    table_row(0, CMD_CLEAR,  2'd0, 24'd0,       13'h0,    1, '{13'h0, 13'h0, 1'b0, 1'b1});
    table_row(0, CMD_SPARE6, 2'd3, 24'hFF_FFFF, 13'h1FFF, 1, QUIET);
    table_row(1, CMD_TICK, CHAN_W'(REG_DOSE_A),    24'd20,      13'h0, 0, QUIET);
    table_row(1, CMD_TICK, CHAN_W'(REG_DOSE_B),    24'd1,       13'h0, 0, QUIET);
    table_row(1, CMD_TICK, CHAN_W'(REG_DOSE_UP),   24'hFF_FFFF, 13'h0, 0, QUIET);
    table_row(1, CMD_TICK, CHAN_W'(REG_DOSE_DOWN), 24'd0,       13'h0, 0, QUIET);
    // pump 0 starts at tick zero and must still time out
    table_row(0, CMD_ON,     2'd0, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_ON,     2'd0, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_ON,     2'd3, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, QUIET);
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, '{13'h1, 13'h1, 1'b1, 1'b0});
    table_row(0, CMD_PULSE,  2'd2, 24'hFF_FFFF, 13'h0,    1, '{13'h1, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_PULSE,  2'd1, 24'd1,       13'h0,    1, '{13'h1, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_PULSE,  2'd1, 24'd2,       13'h0,    1, '{13'h3, 13'h2, 1'b1, 1'b0});
    table_row(0, CMD_RAISE,  2'd0, 24'd0,       13'h1FFF, 1, '{13'h1FFF, 13'h1FFC, 1'b1, 1'b0});
    table_row(0, CMD_RAISE,  2'd0, 24'd0,       13'h0,    1, '{13'h1FFF, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_CLEAR,  2'd0, 24'd0,       13'h1000, 1, '{13'h0FFF, 13'h0, 1'b1, 1'b0});
    // pump 0 still overdue but its bit is already latched
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, '{13'h0FFF, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_CLEAR,  2'd0, 24'd0,       13'h0,    1, '{13'h0, 13'h0, 1'b0, 1'b1});
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, '{13'h1, 13'h1, 1'b1, 1'b0});
    table_row(0, CMD_OFF,    2'd0, 24'd0,       13'h0,    1, '{13'h1, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    1, '{13'h1, 13'h0, 1'b1, 1'b0});
    table_row(0, CMD_ON,     2'd1, 24'd0,       13'h0,    0, QUIET);
    table_row(0, CMD_TICK,   2'd0, 24'd0,       13'h0,    0, QUIET);
    table_row(0, CMD_SPARE7, 2'd2, 24'h5A_A5A5, 13'h0AAA, 0, QUIET);
    table_row(0, CMD_CLEAR,  2'd0, 24'd0,       13'h0003, 1, '{13'h0, 13'h0, 1'b0, 1'b1});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        program_limit(int'(dir_rows[k].ch), dir_rows[k].pulse);
      end else begin
        send_request(dir_rows[k].cmd, dir_rows[k].ch, dir_rows[k].pulse, dir_rows[k].bits,
                     dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // random phases: mostly on/tick/off runs that time out, with clears to recover
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (phase == 3) begin
          program_limit(i, 24'hFF_FFFF);
        end else if (phase == 4) begin
          program_limit(i, 24'd0);
        end else begin
          program_limit(i, pick_limit());
        end
      end
      calm = (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r     = $urandom_range(0, 99);
        ch    = CHAN_W'($urandom_range(0, 3));
        pulse = LIMIT_W'($urandom());
        bits  = FAULT_BITS'($urandom());
        if (r < 38) begin
          cmd = CMD_TICK;
        end else if (r < 53) begin
          cmd = CMD_ON;
        end else if (r < 61) begin
          cmd = CMD_OFF;
        end else if (r < 71) begin
          cmd = CMD_PULSE;
          // half the pulses sit right at the limit
          if ($urandom_range(0, 1) == 0) begin
            pulse = dose_limit[ch] + LIMIT_W'($urandom_range(0, 2)) - 24'd1;
          end
        end else if (r < 79) begin
          cmd = CMD_RAISE;
          r   = $urandom_range(0, 9);
          if (r == 0) begin
            bits = '0;
          end else if (r < 5) begin
            bits = FAULT_BITS'(1) << $urandom_range(0, FAULT_BITS - 1);
          end
        end else if (r < 93) begin
          cmd = CMD_CLEAR;
          r   = $urandom_range(0, 9);
          if (r < 4) begin
            bits = '0;
          end else if (r < 7) begin
            bits = FAULT_BITS'(1) << $urandom_range(0, FAULT_BITS - 1);
          end
        end else begin
          cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE6 : CMD_SPARE7;
        end
        send_request(cmd, ch, pulse, bits, 1'b0, QUIET);
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("dose_pump_watchdog_core regression: pass");
    end else begin
      $display("dose_pump_watchdog_core regression: fail");
    end
    $finish;
  end

endmodule
